[rtl/core/wimu_pkg.sv]
// Package for the wide integer multiplier: sizes, index types, FSM states
// and the command struct passed from the controller to the datapath.
// No dependencies.
package wimu_pkg;

    // Operand and product geometry.
    localparam int OPERAND_BYTES = 128;
    localparam int WORD_W        = 64;
    localparam int HALF_W        = WORD_W / 2;
    localparam int OPERAND_WORDS = OPERAND_BYTES / 8;
    localparam int PRODUCT_WORDS = 2 * OPERAND_WORDS;
    localparam int OP_IDX_W      = $clog2(OPERAND_WORDS);
    localparam int PR_IDX_W      = $clog2(PRODUCT_WORDS);

    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [HALF_W-1:0]   t_half;
    typedef logic [OP_IDX_W-1:0] t_op_idx;
    typedef logic [PR_IDX_W-1:0] t_pr_idx;

    // Which 32-bit halves of the operand words go into the multiplier.
    typedef enum logic [1:0] {
        PH_LL = 2'd0,
        PH_LH = 2'd1,
        PH_HL = 2'd2,
        PH_HH = 2'd3
    } t_mul_phase;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_WB,
        S_CARRY,
        S_ORD,
        S_OWAIT
    } t_ctl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       store_wr;
        t_op_idx    store_wr_addr;
        logic       store_rd;
        t_op_idx    a_rd_addr;
        t_op_idx    b_rd_addr;
        logic       acc_rd;
        t_pr_idx    acc_rd_addr;
        logic       mul_en;
        t_mul_phase mul_phase;
        logic       sum_init;
        logic       use_acc;
        logic       use_carry;
        logic       sum_add;
        logic       acc_wr;
        logic       acc_wr_carry;
        t_pr_idx    acc_wr_addr;
        logic       carry_ld;
    } t_dp_cmd;

endpackage

[rtl/core/wimu_if.sv]
// Valid/ready channel interfaces for operand words and product words.
// Depends on wimu_pkg for the word type.
interface wimu_in_if;
    logic              valid;
    logic              ready;
    wimu_pkg::t_word   a_word;
    wimu_pkg::t_word   b_word;
    logic              last_word;

    modport source (output valid, output a_word, output b_word, output last_word,
                    input ready);
    modport sink   (input valid, input a_word, input b_word, input last_word,
                    output ready);
endinterface

interface wimu_out_if;
    logic              valid;
    logic              ready;
    wimu_pkg::t_word   product_word;
    logic              product_last;

    modport source (output valid, output product_word, output product_last,
                    input ready);
    modport sink   (input valid, input product_word, input product_last,
                    output ready);
endinterface

[rtl/core/wimu_datapath.sv]
// Datapath of the wide multiplier: operand stores, product accumulator memory,
// a shared 32x32 multiplier and the 128-bit multiply-accumulate register.
// Depends on wimu_pkg.
module wimu_datapath (
    input  logic              i_clk,
    input  wimu_pkg::t_dp_cmd i_cmd,
    input  wimu_pkg::t_word   i_a_word,
    input  wimu_pkg::t_word   i_b_word,
    output wimu_pkg::t_word   o_acc_word
);
    import wimu_pkg::*;

    // Operand stores and accumulator memory.
    t_word r_a_mem   [OPERAND_WORDS];
    t_word r_b_mem   [OPERAND_WORDS];
    t_word r_acc_mem [PRODUCT_WORDS];

    t_word r_a_rd;
    t_word r_b_rd;
    t_word r_acc_rd;

    // Multiplier and accumulation registers.
    logic [WORD_W-1:0]   r_pp;
    t_mul_phase          r_pp_phase;
    logic [2*WORD_W-1:0] r_sum;
    t_word               r_carry;

    t_half               mul_x;
    t_half               mul_y;
    logic [2*WORD_W-1:0] pp_shifted;
    t_word               init_acc;
    t_word               init_carry;
    t_word               acc_wr_data;

    // Operand stores: written on each input transfer, read with a registered port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr) begin
            r_a_mem[i_cmd.store_wr_addr] <= i_a_word;
            r_b_mem[i_cmd.store_wr_addr] <= i_b_word;
        end
        if (i_cmd.store_rd) begin
            r_a_rd <= r_a_mem[i_cmd.a_rd_addr];
            r_b_rd <= r_b_mem[i_cmd.b_rd_addr];
        end
    end

    // Accumulator write data is either the low half of the sum or the row carry.
    assign acc_wr_data = i_cmd.acc_wr_carry ? r_carry : r_sum[WORD_W-1:0];

    // Accumulator memory with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_wr) begin
            r_acc_mem[i_cmd.acc_wr_addr] <= acc_wr_data;
        end
        if (i_cmd.acc_rd) begin
            r_acc_rd <= r_acc_mem[i_cmd.acc_rd_addr];
        end
    end

    assign o_acc_word = r_acc_rd;

    // Select the operand halves for the current partial product.
    always_comb begin
        unique case (i_cmd.mul_phase)
            PH_LL: begin
                mul_x = r_a_rd[HALF_W-1:0];
                mul_y = r_b_rd[HALF_W-1:0];
            end
            PH_LH: begin
                mul_x = r_a_rd[HALF_W-1:0];
                mul_y = r_b_rd[WORD_W-1:HALF_W];
            end
            PH_HL: begin
                mul_x = r_a_rd[WORD_W-1:HALF_W];
                mul_y = r_b_rd[HALF_W-1:0];
            end
            PH_HH: begin
                mul_x = r_a_rd[WORD_W-1:HALF_W];
                mul_y = r_b_rd[WORD_W-1:HALF_W];
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    // Registered 32x32 partial product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_pp       <= WORD_W'(mul_x) * WORD_W'(mul_y);
            r_pp_phase <= i_cmd.mul_phase;
        end
    end

    // Align the previous partial product to its weight.
    always_comb begin
        unique case (r_pp_phase)
            PH_LL:   pp_shifted = {{WORD_W{1'b0}}, r_pp};
            PH_LH:   pp_shifted = {{HALF_W{1'b0}}, r_pp, {HALF_W{1'b0}}};
            PH_HL:   pp_shifted = {{HALF_W{1'b0}}, r_pp, {HALF_W{1'b0}}};
            PH_HH:   pp_shifted = {r_pp, {WORD_W{1'b0}}};
            default: pp_shifted = '0;
        endcase
    end

    assign init_acc   = i_cmd.use_acc   ? r_acc_rd : '0;
    assign init_carry = i_cmd.use_carry ? r_carry  : '0;

    // Sum = accumulator word + carry + the LL, LH and HL partial products; it never exceeds 128 bits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_init) begin
            r_sum <= (2*WORD_W)'(init_acc) + (2*WORD_W)'(init_carry);
        end else if (i_cmd.sum_add) begin
            r_sum <= r_sum + pp_shifted;
        end
    end

    // The last partial product only touches the high half, so it lands in the carry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.carry_ld) begin
            r_carry <= r_sum[2*WORD_W-1:WORD_W] + r_pp;
        end
    end

endmodule

[rtl/core/wimu_ctrl.sv]
// Controller of the wide multiplier: operand loading, the row/column loop of
// the schoolbook multiplication and the product readout sequence.
// Depends on wimu_pkg.
module wimu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output logic              o_out_last,
    input  logic              i_out_ready,
    output wimu_pkg::t_dp_cmd o_cmd
);
    import wimu_pkg::*;

    t_ctl_state r_state,    n_state;
    t_op_idx    r_load_pos, n_load_pos;
    t_op_idx    r_i,        n_i;
    t_op_idx    r_j,        n_j;
    t_pr_idx    r_out_idx,  n_out_idx;
    logic       r_pending,  n_pending;

    logic       in_xfer;
    logic       start_req;
    t_pr_idx    acc_idx;

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_load_pos <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_out_idx  <= '0;
            r_pending  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_load_pos <= n_load_pos;
            r_i        <= n_i;
            r_j        <= n_j;
            r_out_idx  <= n_out_idx;
            r_pending  <= n_pending;
        end
    end

    // Input is taken while idle or while the product is read out, unless a start waits.
    assign o_in_ready  = (r_state == S_IDLE || r_state == S_ORD || r_state == S_OWAIT)
                         && !r_pending;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign start_req   = r_pending || (in_xfer && i_in_last);
    assign o_out_valid = (r_state == S_OWAIT);
    assign o_out_last  = (r_out_idx == '0);
    assign acc_idx     = t_pr_idx'(r_i) + t_pr_idx'(r_j);

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_load_pos = r_load_pos;
        n_i        = r_i;
        n_j        = r_j;
        n_out_idx  = r_out_idx;
        n_pending  = r_pending;
        o_cmd      = '0;

        // Each input transfer writes the next store slot.
        o_cmd.store_wr      = in_xfer;
        o_cmd.store_wr_addr = r_load_pos;
        if (in_xfer) begin
            if (i_in_last) begin
                n_load_pos = '0;
                if (r_state != S_IDLE) begin
                    n_pending = 1'b1;
                end
            end else if (r_load_pos == t_op_idx'(OPERAND_WORDS - 1)) begin
                n_load_pos = '0;
            end else begin
                n_load_pos = r_load_pos + t_op_idx'(1);
            end
        end

        o_cmd.a_rd_addr   = t_op_idx'(OPERAND_WORDS - 1) - r_j;
        o_cmd.b_rd_addr   = t_op_idx'(OPERAND_WORDS - 1) - r_i;
        o_cmd.acc_rd_addr = acc_idx;
        o_cmd.acc_wr_addr = acc_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && i_in_last) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                // Fetch operand words and the accumulator word for this step.
                o_cmd.store_rd = 1'b1;
                o_cmd.acc_rd   = 1'b1;
                n_state        = S_M0;
            end
            S_M0: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_phase = PH_LL;
                o_cmd.sum_init  = 1'b1;
                o_cmd.use_acc   = (r_i != '0);
                o_cmd.use_carry = (r_j != '0);
                n_state         = S_M1;
            end
            S_M1: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_phase = PH_LH;
                o_cmd.sum_add   = 1'b1;
                n_state         = S_M2;
            end
            S_M2: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_phase = PH_HL;
                o_cmd.sum_add   = 1'b1;
                n_state         = S_M3;
            end
            S_M3: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_phase = PH_HH;
                o_cmd.sum_add   = 1'b1;
                n_state         = S_WB;
            end
            S_WB: begin
                // Store the low word and keep the high word as the running carry.
                o_cmd.acc_wr   = 1'b1;
                o_cmd.carry_ld = 1'b1;
                if (r_j == t_op_idx'(OPERAND_WORDS - 1)) begin
                    n_state = S_CARRY;
                end else begin
                    n_j     = r_j + t_op_idx'(1);
                    n_state = S_RD;
                end
            end
            S_CARRY: begin
                // The row carry becomes the word just above the row.
                o_cmd.acc_wr       = 1'b1;
                o_cmd.acc_wr_carry = 1'b1;
                o_cmd.acc_wr_addr  = t_pr_idx'(r_i) + t_pr_idx'(OPERAND_WORDS);
                n_j                = '0;
                if (r_i == t_op_idx'(OPERAND_WORDS - 1)) begin
                    n_i       = '0;
                    n_out_idx = t_pr_idx'(PRODUCT_WORDS - 1);
                    n_state   = S_ORD;
                end else begin
                    n_i     = r_i + t_op_idx'(1);
                    n_state = S_RD;
                end
            end
            S_ORD: begin
                o_cmd.acc_rd      = 1'b1;
                o_cmd.acc_rd_addr = r_out_idx;
                n_state           = S_OWAIT;
            end
            S_OWAIT: begin
                // The read register holds the product word until it is taken.
                if (i_out_ready) begin
                    if (r_out_idx == '0) begin
                        if (start_req) begin
                            n_pending = 1'b0;
                            n_state   = S_RD;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_out_idx = r_out_idx - t_pr_idx'(1);
                        n_state   = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/wide_integer_multiplier_unit.sv]
// Top level of the wide integer multiplier: joins the controller and the
// datapath to the operand and product channels.
// Depends on wimu_pkg, wimu_if, wimu_ctrl and wimu_datapath.
//
// Usage: operands arrive on i_op as pairs of 64-bit words (a_word, b_word),
// most significant word first, 16 transfers per 1024-bit operand pair. The
// transfer with last_word set starts the multiplication. The full 2048-bit
// product then leaves on o_prod as 32 words, most significant first, with
// product_last on the final word.
// Each word product uses the single 32x32 multiplier four times, so a
// multiply-accumulate step passes through S_RD, S_M0 to S_M3 and S_WB; each
// row of 16 steps then ends with one row-carry write in S_CARRY.
// Readout reads each product word from memory (S_ORD), then holds it (S_OWAIT).
// Input words are accepted while idle and during readout; a last word taken
// during readout starts the next multiplication once readout ends.
// Reset clears the controller; the stores need no clearing. A stalled
// receiver holds the product word on o_prod until it is taken.
module wide_integer_multiplier_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    wimu_in_if.sink          i_op,
    wimu_out_if.source       o_prod
);
    import wimu_pkg::*;

    t_dp_cmd dp_cmd;

    // Sequencing of loads, multiply steps and readout.
    wimu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_op.valid),
        .i_in_last   (i_op.last_word),
        .o_in_ready  (i_op.ready),
        .o_out_valid (o_prod.valid),
        .o_out_last  (o_prod.product_last),
        .i_out_ready (o_prod.ready),
        .o_cmd       (dp_cmd)
    );

    // Storage and arithmetic.
    wimu_datapath u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (dp_cmd),
        .i_a_word   (i_op.a_word),
        .i_b_word   (i_op.b_word),
        .o_acc_word (o_prod.product_word)
    );

endmodule
